// ===== design/pkfwrl_pkg.sv =====
package pkfwrl_pkg;

	localparam int unsigned DEF_TOPICS    = 64;
	localparam int unsigned DEF_TIME_BITS = 48;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned CFG_DATA_W    = 32;
	localparam int unsigned CNT_W         = 32;
	localparam int unsigned WIN_W         = 32;
	localparam logic [31:0] RST_INTERVAL  = 32'd1000;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE    = 2'd0,
		REG_HAS_LIMIT = 2'd1,
		REG_MAX_COUNT = 2'd2,
		REG_INTERVAL  = 2'd3
	} cfg_reg_t;

	// item kinds
	localparam logic KIND_MSG  = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_DIV,
		ST_WRITE,
		ST_OUT
	} state_t;

	// request and status between the top level and the remainder unit
	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic done;
	} div_sts_t;

endpackage

// ===== design/per_key_fixed_window_rate_limiter_unit.sv =====
// a message needing no window move passes the states read, eval, write and out;
// a window move puts div after eval (bit-serial remainder, one bit per cycle);
// while disabled a message goes from read to out; loads end after read, with no result
// one item is in work at a time: the next transfer can come as the result is shown
// a result still waiting on the output side holds the block in its last state
// reset: arst_n clears seen and override flags, control state, config and output regs
module per_key_fixed_window_rate_limiter_unit #(
	parameter int unsigned TOPICS    = pkfwrl_pkg::DEF_TOPICS,
	parameter int unsigned TIME_BITS = pkfwrl_pkg::DEF_TIME_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pkfwrl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pkfwrl_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                kind,
	input  logic [5:0]                          topic,
	input  logic [47:0]                         timestamp,
	input  logic                                ovr_present,
	input  logic                                ovr_limit_on,
	input  logic [31:0]                         ovr_max,
	input  logic [31:0]                         ovr_window,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                exceeds
);
	import pkfwrl_pkg::*;

	localparam int unsigned AW = (TOPICS > 1) ? $clog2(TOPICS) : 1;
	localparam int unsigned TW = 6;
	// topic entry: limit_on, count, start, len, limit
	localparam int unsigned EW = 1 + CNT_W + TIME_BITS + WIN_W + WIN_W;
	// override entry: limit_on, max, window
	localparam int unsigned OW = 1 + WIN_W + WIN_W;

	// configuration registers
	logic             enable_q;
	logic             has_limit_q;
	logic [31:0]      max_count_q;
	logic [31:0]      interval_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			has_limit_q <= 1'b0;
			max_count_q <= '0;
			interval_q  <= RST_INTERVAL;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_ENABLE:    enable_q    <= cfg_data[0];
				REG_HAS_LIMIT: has_limit_q <= cfg_data[0];
				REG_MAX_COUNT: max_count_q <= cfg_data;
				REG_INTERVAL:  interval_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// captured item
	logic                 kind_q;
	logic [TW-1:0]        topic_q;
	logic [TIME_BITS-1:0] ts_q;
	logic                 present_q;
	logic                 lim_on_q;
	logic [31:0]          omax_q;
	logic [31:0]          owin_q;
	logic [AW-1:0]        addr;
	logic                 in_range;

	assign addr     = AW'(topic_q);
	assign in_range = ({26'd0, topic_q} < 32'(TOPICS));

	// valid flags in flip-flops
	logic [TOPICS-1:0] seen_q;
	logic [TOPICS-1:0] ovr_valid_q;

	state_t state_q, state_d;

	logic          ent_we;
	logic [EW-1:0] ent_wdata;
	logic [EW-1:0] ent_rdata;
	logic          ovr_we;
	logic [OW-1:0] ovr_rdata;

	pkfwrl_ram #(.WIDTH(EW), .DEPTH(TOPICS)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (addr),
		.wdata (ent_wdata),
		.raddr (addr),
		.rdata (ent_rdata)
	);

	pkfwrl_ram #(.WIDTH(OW), .DEPTH(TOPICS)) u_ovr_ram (
		.clk   (clk),
		.we    (ovr_we),
		.waddr (addr),
		.wdata ({lim_on_q, omax_q, owin_q}),
		.raddr (addr),
		.rdata (ovr_rdata)
	);

	// fields of the read entry
	logic                 r_on;
	logic [CNT_W-1:0]     r_cnt;
	logic [TIME_BITS-1:0] r_start;
	logic [WIN_W-1:0]     r_len;
	logic [WIN_W-1:0]     r_lim;

	assign {r_on, r_cnt, r_start, r_len, r_lim} = ent_rdata;

	// working entry
	logic                 w_on_q;
	logic [CNT_W-1:0]     w_cnt_q;
	logic [TIME_BITS-1:0] w_start_q;
	logic [WIN_W-1:0]     w_len_q;
	logic [WIN_W-1:0]     w_lim_q;

	logic [TIME_BITS-1:0] elapsed;
	logic [WIN_W-1:0]     len_eff;
	logic                 expired;

	assign elapsed = ts_q - r_start;
	assign len_eff = (r_len == '0) ? WIN_W'(1) : r_len;
	assign expired = (ts_q >= r_start) &&
		({{(64-TIME_BITS){1'b0}}, elapsed} >= {32'd0, len_eff});

	div_ctl_t         dctl;
	div_sts_t         dsts;
	logic [WIN_W-1:0] drem;

	pkfwrl_rem #(.NUM_W(TIME_BITS), .DEN_W(WIN_W)) u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (dctl),
		.num    (elapsed),
		.den    (len_eff),
		.sts    (dsts),
		.rem    (drem)
	);

	logic [CNT_W-1:0] cnt_inc;
	assign cnt_inc = (w_cnt_q == '1) ? w_cnt_q : w_cnt_q + CNT_W'(1);

	logic out_valid_q;
	logic exceeds_q;
	logic res_val_q;

	// sequencer
	always_comb begin
		state_d   = state_q;
		in_ready  = (state_q == ST_IDLE);
		ovr_we    = 1'b0;
		ent_we    = 1'b0;
		dctl.start = 1'b0;
		ent_wdata = {w_on_q, cnt_inc, w_start_q, w_len_q, w_lim_q};
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (kind_q == KIND_LOAD) begin
					ovr_we  = in_range;
					state_d = ST_IDLE;
				end else if (!enable_q || !in_range) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (seen_q[addr] && r_on && expired) begin
					dctl.start = 1'b1;
					state_d    = ST_DIV;
				end else begin
					state_d = ST_WRITE;
				end
			end
			ST_DIV: begin
				if (dsts.done) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				ent_we  = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			kind_q    <= kind;
			topic_q   <= topic;
			ts_q      <= TIME_BITS'(timestamp);
			present_q <= ovr_present;
			lim_on_q  <= ovr_limit_on;
			omax_q    <= ovr_max;
			owin_q    <= ovr_window;
		end
	end

	// entry modify
	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL) begin
			if (!seen_q[addr]) begin
				if (ovr_valid_q[addr]) begin
					w_on_q  <= ovr_rdata[OW-1];
					w_lim_q <= ovr_rdata[OW-1] ? ovr_rdata[2*WIN_W-1:WIN_W] : '0;
					w_len_q <= ovr_rdata[OW-1] ? ovr_rdata[WIN_W-1:0] : '0;
					w_start_q <= ovr_rdata[OW-1] ? ts_q : '0;
				end else begin
					w_on_q    <= has_limit_q;
					w_lim_q   <= has_limit_q ? max_count_q : '0;
					w_len_q   <= has_limit_q ? interval_q : '0;
					w_start_q <= has_limit_q ? ts_q : '0;
				end
				w_cnt_q <= '0;
			end else begin
				w_on_q    <= r_on;
				w_lim_q   <= r_lim;
				w_len_q   <= r_len;
				w_start_q <= r_start;
				w_cnt_q   <= r_cnt;
			end
		end else if (state_q == ST_DIV && dsts.done) begin
			w_start_q <= ts_q - TIME_BITS'(drem);
			w_cnt_q   <= '0;
		end
	end

	// flags and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= '0;
			ovr_valid_q <= '0;
			out_valid_q <= 1'b0;
			exceeds_q   <= 1'b0;
			res_val_q   <= 1'b0;
		end else begin
			if (ovr_we) begin
				ovr_valid_q[addr] <= present_q;
			end
			if (state_q == ST_READ) begin
				res_val_q  <= 1'b0;
			end
			if (ent_we) begin
				seen_q[addr] <= 1'b1;
				res_val_q    <= w_on_q && (cnt_inc > w_lim_q);
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
				exceeds_q   <= res_val_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign exceeds   = exceeds_q;

endmodule

// ===== design/pkfwrl_ram.sv =====
module pkfwrl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                            clk,
	input  logic                                            we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    waddr,
	input  logic [WIDTH-1:0]                                wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    raddr,
	output logic [WIDTH-1:0]                                rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/pkfwrl_rem.sv =====
module pkfwrl_rem #(
	parameter int unsigned NUM_W = 48,
	parameter int unsigned DEN_W = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pkfwrl_pkg::div_ctl_t    ctl,
	input  logic [NUM_W-1:0]        num,
	input  logic [DEN_W-1:0]        den,
	output pkfwrl_pkg::div_sts_t    sts,
	output logic [DEN_W-1:0]        rem
);
	import pkfwrl_pkg::*;

	localparam int unsigned CNT_BITS = $clog2(NUM_W + 1);

	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [NUM_W-1:0]    num_q;
	logic [DEN_W:0]      rem_q;
	logic [DEN_W-1:0]    den_q;
	logic [DEN_W:0]      trial;
	logic [DEN_W:0]      diff;

	// one restoring step per cycle, numerator bit shifted in from the top
	always_comb begin
		trial = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= diff[DEN_W] ? trial : diff;
		end
	end

	assign rem      = rem_q[DEN_W-1:0];
	assign sts.done = done_q;

endmodule

// ===== design/pkfwrl_checker.sv =====
module pkfwrl_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic kind,
	input logic out_valid,
	input logic out_ready,
	input logic exceeds
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(exceeds))
		else $error("result changed while stalled");

	// one item at a time: no input transfer right after one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken during work");

	// a load taken while no result is waiting gives no result
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind && !out_valid |=> ##1 !out_valid)
		else $error("load produced a result");

endmodule

bind per_key_fixed_window_rate_limiter_unit pkfwrl_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.kind      (kind),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.exceeds   (exceeds)
);
